[rtl/kth_ancestor_binary_lifting_defines.svh]
// Assertion macros used by the ancestor lookup sequencer.
`ifndef KTH_ANCESTOR_BINARY_LIFTING_DEFINES_SVH
`define KTH_ANCESTOR_BINARY_LIFTING_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define KAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define KAB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/kab_pkg.sv]
// Shared types and constants of the ancestor lookup block.
package kab_pkg;

  localparam int unsigned FIELD_W = 10;

  typedef logic [FIELD_W-1:0] field_t;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

[rtl/kth_ancestor_binary_lifting.sv]
// Top level of the k-th ancestor lookup block built on a binary-lifting jump table.
//
// Input channel (in_valid_i/in_ready_o): a beat with req_type_i = 0 loads node_i under
// parent_node_i; parents must be loaded before their children. A beat with
// req_type_i = 1 asks for the steps_i-th ancestor of node_i.
// Output channel (out_valid_o/out_ready_i): one beat per query with ancestor_o and
// found_o; loads give no beat. found_o is 0, with ancestor_o 0, when the steps
// exceed the node's depth or the node is out of range.
// Each level of a load or query needs one read of the jump-table RAM whose address
// is the data of the read before; a query that the depth check rejects stops after
// its first level.
// The result sits in an output register, so the next beat is accepted while a
// result waits; a query that finishes while the receiver stalls holds in its
// last state until the register frees.
// Reset clears the sequencer and the output register only. The RAMs are not
// cleared: the root row and depth read as zero by construction, and any other
// node must be loaded before it is used.
module kth_ancestor_binary_lifting #(
  parameter int unsigned NODES  = 1024,
  parameter int unsigned LEVELS = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            req_type_i,
  input  kab_pkg::field_t node_i,
  input  kab_pkg::field_t parent_node_i,
  input  kab_pkg::field_t steps_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output kab_pkg::field_t ancestor_o,
  output logic            found_o
);

  import kab_pkg::*;

  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic             jt_we;
  logic [NW+LW-1:0] jt_waddr;
  field_t           jt_wdata;
  logic [NW+LW-1:0] jt_raddr;
  field_t           jt_rdata;
  logic             dp_we;
  logic [NW-1:0]    dp_waddr;
  field_t           dp_wdata;
  logic [NW-1:0]    dp_raddr;
  field_t           dp_rdata;

  kab_ctrl #(
    .NODES  (NODES),
    .LEVELS (LEVELS),
    .NW     (NW),
    .LW     (LW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .node_i        (node_i),
    .parent_node_i (parent_node_i),
    .steps_i       (steps_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ancestor_o    (ancestor_o),
    .found_o       (found_o),
    .jt_we_o       (jt_we),
    .jt_waddr_o    (jt_waddr),
    .jt_wdata_o    (jt_wdata),
    .jt_raddr_o    (jt_raddr),
    .jt_rdata_i    (jt_rdata),
    .dp_we_o       (dp_we),
    .dp_waddr_o    (dp_waddr),
    .dp_wdata_o    (dp_wdata),
    .dp_raddr_o    (dp_raddr),
    .dp_rdata_i    (dp_rdata)
  );

  // Jump table: row per node, one entry per level.
  kab_ram #(
    .ADDR_W (NW + LW),
    .DATA_W (FIELD_W)
  ) u_jump_ram (
    .clk_i   (clk_i),
    .we_i    (jt_we),
    .waddr_i (jt_waddr),
    .wdata_i (jt_wdata),
    .raddr_i (jt_raddr),
    .rdata_o (jt_rdata)
  );

  kab_ram #(
    .ADDR_W (NW),
    .DATA_W (FIELD_W)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (dp_we),
    .waddr_i (dp_waddr),
    .wdata_i (dp_wdata),
    .raddr_i (dp_raddr),
    .rdata_o (dp_rdata)
  );

endmodule

[rtl/kab_ram.sv]
// Simple dual-port synchronous RAM with a registered read port.
module kab_ram #(
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/kab_ctrl.sv]
// Sequencer that walks the jump table level by level for loads and queries.
`include "kth_ancestor_binary_lifting_defines.svh"

module kab_ctrl #(
  parameter int unsigned NODES  = 1024,
  parameter int unsigned LEVELS = 10,
  parameter int unsigned NW     = 10,
  parameter int unsigned LW     = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                req_type_i,
  input  kab_pkg::field_t     node_i,
  input  kab_pkg::field_t     parent_node_i,
  input  kab_pkg::field_t     steps_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kab_pkg::field_t     ancestor_o,
  output logic                found_o,
  output logic                jt_we_o,
  output logic [NW+LW-1:0]    jt_waddr_o,
  output kab_pkg::field_t     jt_wdata_o,
  output logic [NW+LW-1:0]    jt_raddr_o,
  input  kab_pkg::field_t     jt_rdata_i,
  output logic                dp_we_o,
  output logic [NW-1:0]       dp_waddr_o,
  output kab_pkg::field_t     dp_wdata_o,
  output logic [NW-1:0]       dp_raddr_o,
  input  kab_pkg::field_t     dp_rdata_i
);

  import kab_pkg::*;

  localparam int unsigned KW = (LEVELS > FIELD_W) ? LEVELS : FIELD_W;
  localparam logic [LW-1:0] LAST_LVL = LW'(LEVELS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_e;

  state_e         state_q;
  logic           is_query_q;
  logic           take_q;
  logic           fail_q;
  logic [LW-1:0]  lvl_q;
  logic           out_valid_q;
  field_t         ancestor_q;
  logic           found_q;

  field_t         n_q;
  field_t         cur_q;
  logic [KW-1:0]  k_q;
  logic           jt_root_q;
  logic           dp_root_q;

  logic           in_accept;
  logic           out_free;
  logic           node_ok;
  logic           load_ok;
  logic           k_hi;
  field_t         jt_val;
  field_t         dp_val;
  field_t         cur_eff;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign node_ok = (32'(node_i) < 32'(NODES));
  assign load_ok = node_ok && (node_i != '0) && (parent_node_i < node_i);
  assign k_hi    = |(steps_i >> LEVELS);

  // The root row and depth are all zeros, so data read for node 0 is replaced by zero.
  assign jt_val  = jt_root_q ? '0 : jt_rdata_i;
  assign dp_val  = dp_root_q ? '0 : dp_rdata_i;
  assign cur_eff = take_q ? jt_val : cur_q;

  assign jt_raddr_o = {NW'(cur_eff), lvl_q};
  assign jt_we_o    = (state_q == S_WALK) && !is_query_q;
  assign jt_waddr_o = {NW'(n_q), lvl_q};
  assign jt_wdata_o = cur_eff;

  assign dp_raddr_o = NW'((req_type_i == REQ_QUERY) ? node_i : parent_node_i);
  assign dp_we_o    = (state_q == S_WALK) && !is_query_q && (lvl_q == '0);
  assign dp_waddr_o = NW'(n_q);
  assign dp_wdata_o = dp_val + FIELD_W'(1);

  assign out_valid_o = out_valid_q;
  assign ancestor_o  = ancestor_q;
  assign found_o     = found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      is_query_q  <= 1'b0;
      take_q      <= 1'b0;
      fail_q      <= 1'b0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
      ancestor_q  <= '0;
      found_q     <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          take_q <= 1'b0;
          lvl_q  <= '0;
          if (in_accept) begin
            if (req_type_i == REQ_QUERY) begin
              is_query_q <= 1'b1;
              fail_q     <= !node_ok || k_hi;
              state_q    <= S_WALK;
            end else if (load_ok) begin
              is_query_q <= 1'b0;
              fail_q     <= 1'b0;
              state_q    <= S_WALK;
            end
          end
        end
        S_WALK: begin
          // Every level costs one read; a clear bit of k just keeps the node.
          take_q <= is_query_q ? k_q[lvl_q] : 1'b1;
          lvl_q  <= lvl_q + LW'(1);
          if (is_query_q && (lvl_q == '0) && (fail_q || (k_q > KW'(dp_val)))) begin
            fail_q  <= 1'b1;
            state_q <= S_FINISH;
          end else if (lvl_q == LAST_LVL) begin
            state_q <= is_query_q ? S_FINISH : S_IDLE;
          end
        end
        S_FINISH: begin
          // The resolved node is folded into cur_q so a stall holds it steady.
          take_q <= 1'b0;
          if (out_free) begin
            out_valid_q <= 1'b1;
            found_q     <= !fail_q;
            ancestor_q  <= fail_q ? '0 : cur_eff;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    jt_root_q <= (NW'(cur_eff) == '0);
    dp_root_q <= (dp_raddr_o == '0);
    if (in_accept) begin
      n_q   <= node_i;
      k_q   <= KW'(steps_i);
      cur_q <= (req_type_i == REQ_QUERY) ? node_i : parent_node_i;
    end else begin
      cur_q <= cur_eff;
    end
  end

  `KAB_NEVER(a_no_root_write, jt_we_o && (n_q == '0), "root row must never be written")
  `KAB_ASSERT(a_depth_after_accept, dp_we_o |-> $past(in_accept), "depth write out of step")
  `KAB_ASSERT(a_miss_is_zero, out_valid_q |-> (found_q || (ancestor_q == '0)), "miss with node")
  `KAB_ASSERT(a_finish_delivers, (state_q == S_FINISH) && out_free |=> out_valid_q,
              "finished query gave no result")

endmodule
